>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the quarter-turn rotation block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk_i and disabled in reset.
`define RQT_ASSERT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i and disabled in reset.
`define RQT_ASSERT_NEXT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error(msg);

`endif

>>> hw/rtl/rqt_pkg.sv
// ----------------------------------------------------------------------------
// rqt_pkg
// Types and constants shared by the quarter-turn rotation block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rqt_pkg;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] pixel_in;
  } rqt_in_t;

  typedef struct packed {
    logic [31:0] pixel_out;
    logic        last;
  } rqt_out_t;

  localparam logic [1:0] OP_STORE = 2'd0;
  localparam logic [1:0] OP_EMIT  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  localparam logic [1:0] ROT_NONE = 2'd0;
  localparam logic [1:0] ROT_CW   = 2'd1;
  localparam logic [1:0] ROT_180  = 2'd2;

  localparam int          CFG_IDX_W       = 3;
  localparam logic [2:0]  REG_WIDTH       = 3'd0;
  localparam logic [2:0]  REG_HEIGHT      = 3'd1;
  localparam logic [2:0]  REG_ROTATION    = 3'd2;
  localparam logic [2:0]  REG_PIXEL_BYTES = 3'd3;

  localparam logic [2:0]  FOUR_BYTES = 3'd4;
  localparam logic [31:0] PIX3_MASK  = 32'h00FF_FFFF;

  localparam int FIFO_DEPTH = 4;

  typedef enum logic [1:0] {
    CMD_STORE,
    CMD_EMIT,
    CMD_START
  } cmd_e;

  typedef struct packed {
    cmd_e        op;
    logic [31:0] pixel;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

  typedef struct packed {
    logic [8:0] width;
    logic [8:0] height;
    logic [1:0] rotation;
    logic [2:0] pixel_bytes;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{width: 9'd256, height: 9'd256,
                                 rotation: ROT_NONE, pixel_bytes: 3'd3};

  typedef enum logic {
    BK_RUN,
    BK_DIV
  } bk_state_e;

endpackage

>>> hw/rtl/rqt_ram.sv
// ----------------------------------------------------------------------------
// rqt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rqt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/rqt_div.sv
// ----------------------------------------------------------------------------
// rqt_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rqt_div import rqt_pkg::*; #(
  parameter int NW = 17,
  parameter int DW = 9
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o,
  output logic [DW-1:0] rem_o
);

  localparam int CW = $clog2(NW + 1);

  logic          run_q, run_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [NW-1:0] quo_q, quo_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] div_q, div_d;
  logic [DW:0]   rem_sh;
  logic [DW:0]   rem_sub;
  logic          ge;
  logic [NW:0]   quo_sh;

  always_comb begin
    rem_sh  = {rem_q, quo_q[NW-1]};
    ge      = (rem_sh >= {1'b0, div_q});
    rem_sub = rem_sh - {1'b0, div_q};
    quo_sh  = {quo_q, ge};
    run_d   = run_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    div_d   = div_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = CW'(NW);
      quo_d = dividend_i;
      rem_d = '0;
      div_d = divisor_i;
    end else if (run_q) begin
      quo_d = quo_sh[NW-1:0];
      rem_d = ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

>>> hw/rtl/rqt_front.sv
// ----------------------------------------------------------------------------
// rqt_front
// Accepts words, decodes the opcode and queues commands for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module rqt_front import rqt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  rqt_in_t in_i,
  input  logic    hold_i,
  input  logic    pop_i,
  output logic    busy_o,
  output head_t   head_o
);

  localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam logic [PW:0] FULL_CNT = FIFO_DEPTH[PW:0];

  cmd_t          fifo_q [FIFO_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PW:0]   cnt_q, cnt_d;
  cmd_t          cmd;
  logic          keep;
  logic          push;

  always_comb begin
    cmd.pixel = in_i.pixel_in;
    cmd.op    = CMD_STORE;
    keep      = 1'b1;
    unique case (in_i.opcode)
      OP_STORE: cmd.op = CMD_STORE;
      OP_EMIT:  cmd.op = CMD_EMIT;
      OP_START: cmd.op = CMD_START;
      default:  keep   = 1'b0;
    endcase
  end

  assign busy_o = (cnt_q == FULL_CNT) || hold_i;
  assign push   = start_i && !busy_o && keep;

  always_comb begin
    wr_ptr_d = push  ? wr_ptr_q + PW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + PW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop_i) begin
      cnt_d = cnt_q + (PW+1)'(1);
    end else if (pop_i && !push) begin
      cnt_d = cnt_q - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = fifo_q[rd_ptr_q];

  `RQT_ASSERT(a_no_pop_when_empty, pop_i, head_o.valid, "back end popped an empty queue")

endmodule

>>> hw/rtl/rqt_back.sv
// ----------------------------------------------------------------------------
// rqt_back
// Executes queued commands: frame store writes, rotated read-out, counters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module rqt_back import rqt_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     cfg_wr_i,
  input  head_t    head_i,
  output logic     pop_o,
  output logic     res_valid_o,
  output rqt_out_t res_o
);

  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int DW    = (WW > HW) ? WW : HW;
  localparam int CIW   = $clog2(MAX_WIDTH);
  localparam int RIW   = $clog2(MAX_HEIGHT);
  localparam int IW0   = (CIW > RIW) ? CIW : RIW;
  localparam int IW    = (IW0 > 1) ? IW0 : 1;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int KW    = $clog2(DEPTH + 1);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  bk_state_e     state_q, state_d;
  logic [WW-1:0] w_c;
  logic [HW-1:0] h_c;
  logic [DW-1:0] d_sel;
  logic [DW-1:0] d_m1;
  logic [IW-1:0] w_m1;
  logic [IW-1:0] h_m1;
  logic [KW-1:0] total_q;
  logic [KW-1:0] load_q, load_d;
  logic [KW-1:0] k_q, k_d;
  logic [IW-1:0] q_q, q_d;
  logic [IW-1:0] r_q, r_d;
  logic          dirty_q, dirty_d;
  logic [IW-1:0] row, col;
  logic          is_last;
  logic          a_valid_q, a_valid_d;
  logic [IW-1:0] a_row_q, a_col_q;
  logic          a_last_q, a_four_q;
  logic          b_valid_q, b_last_q, b_four_q;
  logic          ram_we;
  logic [KW-1:0] addr_full;
  logic [31:0]   ram_rdata;
  logic          div_start;
  logic          div_done;
  logic [KW-1:0] div_quo;
  logic [DW-1:0] div_rem;

  always_comb begin
    if (cfg_i.width == '0) begin
      w_c = WW'(1);
    end else if (int'(cfg_i.width) > MAX_WIDTH) begin
      w_c = WW'(MAX_WIDTH);
    end else begin
      w_c = WW'(cfg_i.width);
    end
    if (cfg_i.height == '0) begin
      h_c = HW'(1);
    end else if (int'(cfg_i.height) > MAX_HEIGHT) begin
      h_c = HW'(MAX_HEIGHT);
    end else begin
      h_c = HW'(cfg_i.height);
    end
  end

  assign d_sel = cfg_i.rotation[0] ? DW'(h_c) : DW'(w_c);
  assign d_m1  = d_sel - DW'(1);
  assign w_m1  = IW'(w_c - WW'(1));
  assign h_m1  = IW'(h_c - HW'(1));

  always_comb begin
    case (cfg_i.rotation)
      ROT_NONE: begin
        row = q_q;
        col = r_q;
      end
      ROT_CW: begin
        row = r_q;
        col = w_m1 - q_q;
      end
      ROT_180: begin
        row = h_m1 - q_q;
        col = w_m1 - r_q;
      end
      default: begin
        row = h_m1 - r_q;
        col = q_q;
      end
    endcase
  end

  assign is_last = (k_q == total_q - KW'(1));

  always_comb begin
    state_d   = state_q;
    load_d    = load_q;
    k_d       = k_q;
    q_d       = q_q;
    r_d       = r_q;
    dirty_d   = dirty_q;
    pop_o     = 1'b0;
    ram_we    = 1'b0;
    a_valid_d = 1'b0;
    div_start = 1'b0;
    unique case (state_q)
      BK_RUN: begin
        if (head_i.valid) begin
          case (head_i.cmd.op)
            CMD_STORE: begin
              pop_o = 1'b1;
              if (load_q < total_q) begin
                ram_we = 1'b1;
                load_d = load_q + KW'(1);
              end
            end
            CMD_START: begin
              pop_o   = 1'b1;
              load_d  = '0;
              k_d     = '0;
              q_d     = '0;
              r_d     = '0;
              dirty_d = 1'b0;
            end
            CMD_EMIT: begin
              if (dirty_q) begin
                if (k_q >= total_q) begin
                  k_d     = '0;
                  q_d     = '0;
                  r_d     = '0;
                  dirty_d = 1'b0;
                end else begin
                  div_start = 1'b1;
                  state_d   = BK_DIV;
                end
              end else begin
                pop_o     = 1'b1;
                a_valid_d = 1'b1;
                if (is_last) begin
                  k_d = '0;
                  q_d = '0;
                  r_d = '0;
                end else begin
                  k_d = k_q + KW'(1);
                  if (DW'(r_q) == d_m1) begin
                    r_d = '0;
                    q_d = q_q + IW'(1);
                  end else begin
                    r_d = r_q + IW'(1);
                  end
                end
              end
            end
            default: pop_o = 1'b1;
          endcase
        end
      end
      BK_DIV: begin
        if (div_done) begin
          q_d     = IW'(div_quo);
          r_d     = IW'(div_rem);
          dirty_d = 1'b0;
          state_d = BK_RUN;
        end
      end
      default: state_d = BK_RUN;
    endcase
    if (cfg_wr_i) begin
      dirty_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_RUN;
      load_q    <= '0;
      k_q       <= '0;
      q_q       <= '0;
      r_q       <= '0;
      dirty_q   <= 1'b1;
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      load_q    <= load_d;
      k_q       <= k_d;
      q_q       <= q_d;
      r_q       <= r_d;
      dirty_q   <= dirty_d;
      a_valid_q <= a_valid_d;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    total_q  <= KW'(w_c) * KW'(h_c);
    a_row_q  <= row;
    a_col_q  <= col;
    a_last_q <= is_last;
    a_four_q <= (cfg_i.pixel_bytes == FOUR_BYTES);
    b_last_q <= a_last_q;
    b_four_q <= a_four_q;
  end

  assign addr_full = KW'(a_row_q) * KW'(w_c) + KW'(a_col_q);

  rqt_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (load_q[AW-1:0]),
    .wdata_i (head_i.cmd.pixel),
    .raddr_i (addr_full[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  rqt_div #(
    .NW (KW),
    .DW (DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (k_q),
    .divisor_i  (d_sel),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  assign res_valid_o     = b_valid_q;
  assign res_o.pixel_out = b_four_q ? ram_rdata : (ram_rdata & PIX3_MASK);
  assign res_o.last      = b_last_q;

  `RQT_ASSERT(a_pos_in_frame, !dirty_q, k_q < total_q, "read position outside the frame")
  `RQT_ASSERT(a_div_needs_resync, state_q == BK_DIV, dirty_q, "divider running without resync")
  `RQT_ASSERT_NEXT(a_result_follows_read, a_valid_q, res_valid_o, "read issued without a result")

endmodule

>>> hw/rtl/image_rotate_quarter_turns_unit.sv
// An emit word passes the queue, the address register and the read register to its result.
// After a register write, the first emit may wait on the serial divider to resync.
// Throughput: one word per cycle unless busy, via a 4-entry queue; a register write sets busy next cycle.
// Each result is shown for one cycle on res_valid_o; the receiver cannot stall.
// Reset clears the counters and loads the register defaults; the frame store is undefined until loaded.
// ----------------------------------------------------------------------------
// image_rotate_quarter_turns_unit
// Frame store loaded in raster order and read back in 0, 90, 180 or 270 order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module image_rotate_quarter_turns_unit import rqt_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  rqt_in_t              in_i,
  output logic                 res_valid_o,
  output rqt_out_t             res_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  cfg_t  cfg_q, cfg_d;
  logic  cfg_fire;
  logic  settle_q;
  logic  pop;
  head_t head;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_fire) begin
      unique case (cfg_index_i)
        REG_WIDTH:       cfg_d.width       = cfg_data_i[8:0];
        REG_HEIGHT:      cfg_d.height      = cfg_data_i[8:0];
        REG_ROTATION:    cfg_d.rotation    = cfg_data_i[1:0];
        REG_PIXEL_BYTES: cfg_d.pixel_bytes = cfg_data_i[2:0];
        default:         cfg_d             = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q    <= CFG_RESET;
      settle_q <= 1'b0;
    end else begin
      cfg_q    <= cfg_d;
      settle_q <= cfg_fire;
    end
  end

  rqt_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .in_i    (in_i),
    .hold_i  (settle_q),
    .pop_i   (pop),
    .busy_o  (busy),
    .head_o  (head)
  );

  rqt_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cfg_wr_i    (cfg_fire),
    .head_i      (head),
    .pop_o       (pop),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule
